FILE: rtl/lres_pkg.sv
package lres_pkg;

    // ring geometry
    localparam int LED_COUNT = 12;
    localparam int LED_W     = $clog2(LED_COUNT);
    localparam int HALF_RING = LED_COUNT / 2;

    // fade lengths in frames
    localparam int MUTE_FRAMES   = 32;
    localparam int UNMUTE_FRAMES = 33;

    // frame queue depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // colors
    localparam logic [7:0] GREEN_G      = 8'h4f;
    localparam logic [7:0] GREEN_B      = 8'h0f;
    localparam logic [7:0] BLUE_B       = 8'h3f;
    localparam logic [7:0] SCROLL_LEVEL = 8'h01;
    localparam logic [7:0] UNMUTE_RED   = 8'h40;
    localparam int         SCROLL_LIT   = 4;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_MODE = 2'd1,
        OP_MIC  = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'd0,
        MODE_START  = 4'd1,
        MODE_ACTIVE = 4'd2,
        MODE_END    = 4'd3,
        MODE_THINK  = 4'd4,
        MODE_SPEAK  = 4'd5,
        MODE_MUTE   = 4'd6,
        MODE_UNMUTE = 4'd7,
        MODE_BTDISC = 4'd8
    } mode_t;

    typedef enum logic [1:0] {
        CFG_SWEEP  = 2'd0,
        CFG_BLINK  = 2'd1,
        CFG_SCROLL = 2'd2,
        CFG_FADE   = 2'd3
    } cfg_idx_t;

    // picture kinds that the back end can render
    typedef enum logic [2:0] {
        KIND_BLACK  = 3'd0,
        KIND_SWEEP  = 3'd1,
        KIND_BLINK  = 3'd2,
        KIND_GREEN  = 3'd3,
        KIND_RED    = 3'd4,
        KIND_SCROLL = 3'd5
    } frame_kind_t;

    // one frame to draw: kind plus sweep position, blink phase, red level or scroll start
    typedef struct packed {
        frame_kind_t kind;
        logic [7:0]  param;
    } frame_desc_t;

endpackage

FILE: rtl/lres_front.sv
module lres_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic [3:0]          mode_req,
    input  logic                mic_muted,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                q_full,
    output logic                q_push,
    output lres_pkg::frame_desc_t q_push_data
);
    import lres_pkg::*;

    mode_t            active_mode_reg, active_mode_next;
    mode_t            pending_mode_reg, pending_mode_next;
    logic [6:0]       anim_step_reg, anim_step_next;
    logic [7:0]       tick_count_reg, tick_count_next;
    logic             blink_phase_reg, blink_phase_next;
    logic [LED_W-1:0] scroll_pos_reg, scroll_pos_next;
    logic             anim_busy_reg, anim_busy_next;
    logic             prev_mic_reg, prev_mic_next;
    logic [7:0]       sweep_ticks_reg, blink_ticks_reg, scroll_ticks_reg, fade_ticks_reg;

    logic             accept;
    logic [7:0]       period_sel;
    logic [7:0]       period;
    logic             due;
    logic [6:0]       step_inc;
    frame_desc_t      end_desc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_ticks_reg  <= 8'd3;
            blink_ticks_reg  <= 8'd10;
            scroll_ticks_reg <= 8'd12;
            fade_ticks_reg   <= 8'd1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SWEEP:  sweep_ticks_reg  <= cfg_data;
                CFG_BLINK:  blink_ticks_reg  <= cfg_data;
                CFG_SCROLL: scroll_ticks_reg <= cfg_data;
                CFG_FADE:   fade_ticks_reg   <= cfg_data;
                default:    sweep_ticks_reg  <= sweep_ticks_reg;
            endcase
        end
    end

    // frame timer of the running mode, zero period acts as one
    always_comb
    begin
        case (active_mode_reg)
            MODE_THINK:              period_sel = blink_ticks_reg;
            MODE_BTDISC:             period_sel = scroll_ticks_reg;
            MODE_MUTE, MODE_UNMUTE:  period_sel = fade_ticks_reg;
            default:                 period_sel = sweep_ticks_reg;
        endcase
        period = (period_sel == 8'd0) ? 8'd1 : period_sel;
        due    = ({1'b0, tick_count_reg} + 9'd1) >= {1'b0, period};
    end

    // next frame of an end sweep
    always_comb
    begin
        step_inc = anim_step_reg + 7'd1;
        if (step_inc > 7'(HALF_RING))
        begin
            end_desc.kind  = KIND_BLACK;
            end_desc.param = 8'd0;
        end
        else
        begin
            end_desc.kind  = KIND_SWEEP;
            end_desc.param = 8'(HALF_RING) - 8'(step_inc);
        end
    end

    // item classification and mode sequencing
    always_comb
    begin
        active_mode_next  = active_mode_reg;
        pending_mode_next = pending_mode_reg;
        anim_step_next    = anim_step_reg;
        tick_count_next   = tick_count_reg;
        blink_phase_next  = blink_phase_reg;
        scroll_pos_next   = scroll_pos_reg;
        anim_busy_next    = anim_busy_reg;
        prev_mic_next     = prev_mic_reg;
        q_push            = 1'b0;
        q_push_data.kind  = KIND_BLACK;
        q_push_data.param = 8'd0;

        if (accept)
        begin
            case (op_t'(op))
                OP_MODE:
                begin
                    if (mode_req <= MODE_BTDISC)
                        pending_mode_next = mode_t'(mode_req);
                end
                OP_MIC:
                begin
                    if (mic_muted != prev_mic_reg)
                    begin
                        if (!mic_muted)
                        begin
                            pending_mode_next = MODE_UNMUTE;
                            prev_mic_next     = 1'b0;
                        end
                        else if (!(pending_mode_reg >= MODE_START &&
                                   pending_mode_reg <= MODE_SPEAK))
                        begin
                            pending_mode_next = MODE_MUTE;
                            prev_mic_next     = 1'b1;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (!anim_busy_reg && pending_mode_reg != active_mode_reg)
                    begin
                        // switch to the wanted mode and show its first frame
                        active_mode_next = pending_mode_reg;
                        anim_step_next   = 7'd0;
                        tick_count_next  = 8'd0;
                        blink_phase_next = 1'b0;
                        scroll_pos_next  = '0;
                        anim_busy_next   = 1'b0;
                        case (pending_mode_reg)
                            MODE_IDLE:
                            begin
                                q_push = 1'b1;
                            end
                            MODE_START:
                            begin
                                anim_busy_next   = 1'b1;
                                q_push           = 1'b1;
                                q_push_data.kind = KIND_SWEEP;
                            end
                            MODE_END:
                            begin
                                anim_busy_next    = 1'b1;
                                anim_step_next    = 7'd1;
                                q_push            = 1'b1;
                                q_push_data.kind  = KIND_SWEEP;
                                q_push_data.param = 8'(HALF_RING - 1);
                            end
                            MODE_THINK:
                            begin
                                q_push           = 1'b1;
                                q_push_data.kind = KIND_BLINK;
                            end
                            MODE_SPEAK:
                            begin
                                anim_busy_next   = 1'b1;
                                q_push           = 1'b1;
                                q_push_data.kind = KIND_GREEN;
                            end
                            MODE_MUTE:
                            begin
                                anim_busy_next   = 1'b1;
                                q_push           = 1'b1;
                                q_push_data.kind = KIND_RED;
                            end
                            MODE_UNMUTE:
                            begin
                                anim_busy_next    = 1'b1;
                                q_push            = 1'b1;
                                q_push_data.kind  = KIND_RED;
                                q_push_data.param = UNMUTE_RED;
                            end
                            MODE_BTDISC:
                            begin
                                scroll_pos_next  = LED_W'(1);
                                q_push           = 1'b1;
                                q_push_data.kind = KIND_SCROLL;
                            end
                            default:
                            begin
                                q_push = 1'b0;
                            end
                        endcase
                    end
                    else
                    begin
                        // advance the running animation
                        case (active_mode_reg)
                            MODE_START:
                            begin
                                if (anim_busy_reg)
                                begin
                                    tick_count_next = due ? 8'd0 : tick_count_reg + 8'd1;
                                    if (due)
                                    begin
                                        anim_step_next = step_inc;
                                        if (step_inc >= 7'(HALF_RING))
                                            anim_busy_next = 1'b0;
                                        else
                                        begin
                                            q_push            = 1'b1;
                                            q_push_data.kind  = KIND_SWEEP;
                                            q_push_data.param = 8'(step_inc);
                                        end
                                    end
                                end
                            end
                            MODE_END, MODE_SPEAK:
                            begin
                                if (anim_busy_reg)
                                begin
                                    if (active_mode_reg == MODE_SPEAK &&
                                        anim_step_reg == 7'd0)
                                    begin
                                        // hold all green until the request moves away
                                        if (pending_mode_reg != MODE_SPEAK)
                                        begin
                                            anim_step_next    = 7'd1;
                                            tick_count_next   = 8'd0;
                                            q_push            = 1'b1;
                                            q_push_data.kind  = KIND_SWEEP;
                                            q_push_data.param = 8'(HALF_RING - 1);
                                        end
                                    end
                                    else
                                    begin
                                        tick_count_next = due ? 8'd0 : tick_count_reg + 8'd1;
                                        if (due)
                                        begin
                                            anim_step_next = step_inc;
                                            q_push         = 1'b1;
                                            q_push_data    = end_desc;
                                            if (step_inc >= 7'(HALF_RING + 1))
                                                anim_busy_next = 1'b0;
                                        end
                                    end
                                end
                            end
                            MODE_THINK:
                            begin
                                tick_count_next = due ? 8'd0 : tick_count_reg + 8'd1;
                                if (due)
                                begin
                                    blink_phase_next  = !blink_phase_reg;
                                    q_push            = 1'b1;
                                    q_push_data.kind  = KIND_BLINK;
                                    q_push_data.param = {7'd0, !blink_phase_reg};
                                end
                            end
                            MODE_MUTE, MODE_UNMUTE:
                            begin
                                if (anim_busy_reg)
                                begin
                                    tick_count_next = due ? 8'd0 : tick_count_reg + 8'd1;
                                    if (due)
                                    begin
                                        anim_step_next = step_inc;
                                        if (active_mode_reg == MODE_MUTE)
                                        begin
                                            if (step_inc >= 7'(MUTE_FRAMES))
                                                anim_busy_next = 1'b0;
                                            else
                                            begin
                                                q_push            = 1'b1;
                                                q_push_data.kind  = KIND_RED;
                                                q_push_data.param = {step_inc, 1'b0};
                                            end
                                        end
                                        else
                                        begin
                                            if (step_inc >= 7'(UNMUTE_FRAMES))
                                                anim_busy_next = 1'b0;
                                            else
                                            begin
                                                q_push            = 1'b1;
                                                q_push_data.kind  = KIND_RED;
                                                q_push_data.param = UNMUTE_RED -
                                                                    {step_inc, 1'b0};
                                            end
                                        end
                                    end
                                end
                            end
                            MODE_BTDISC:
                            begin
                                tick_count_next = due ? 8'd0 : tick_count_reg + 8'd1;
                                if (due)
                                begin
                                    q_push            = 1'b1;
                                    q_push_data.kind  = KIND_SCROLL;
                                    q_push_data.param = 8'(scroll_pos_reg);
                                    if (scroll_pos_reg == LED_W'(LED_COUNT - 1))
                                        scroll_pos_next = '0;
                                    else
                                        scroll_pos_next = scroll_pos_reg + LED_W'(1);
                                end
                            end
                            default:
                            begin
                                q_push = 1'b0;
                            end
                        endcase
                    end
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    // mode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_mode_reg  <= MODE_IDLE;
            pending_mode_reg <= MODE_IDLE;
            anim_step_reg    <= 7'd0;
            tick_count_reg   <= 8'd0;
            blink_phase_reg  <= 1'b0;
            scroll_pos_reg   <= '0;
            anim_busy_reg    <= 1'b0;
            prev_mic_reg     <= 1'b0;
        end
        else
        begin
            active_mode_reg  <= active_mode_next;
            pending_mode_reg <= pending_mode_next;
            anim_step_reg    <= anim_step_next;
            tick_count_reg   <= tick_count_next;
            blink_phase_reg  <= blink_phase_next;
            scroll_pos_reg   <= scroll_pos_next;
            anim_busy_reg    <= anim_busy_next;
            prev_mic_reg     <= prev_mic_next;
        end
    end

endmodule

FILE: rtl/lres_queue.sv
module lres_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lres_pkg::frame_desc_t push_data,
    output logic                  full,
    input  logic                  pop,
    output lres_pkg::frame_desc_t pop_data,
    output logic                  empty
);
    import lres_pkg::*;

    frame_desc_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + (QPTR_W + 1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/lres_back.sv
module lres_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  lres_pkg::frame_desc_t q_pop_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [3:0]            led_index,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic                  last
);
    import lres_pkg::*;

    frame_desc_t      desc_reg;
    logic [LED_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             out_valid_reg, out_valid_next;
    logic [3:0]       led_index_reg;
    logic [7:0]       red_reg, green_reg, blue_reg;
    logic             last_reg;

    logic             load;
    logic             emit;
    logic             cnt_last;
    logic [7:0]       idx;
    logic [7:0]       mirror;
    logic [7:0]       ring_dist;
    logic [7:0]       px_r, px_g, px_b;

    assign load     = !out_valid_reg || out_ready;
    assign emit     = load && busy_reg;
    assign cnt_last = (cnt_reg == LED_W'(LED_COUNT - 1));
    assign q_pop    = !q_empty && (!busy_reg || (emit && cnt_last));

    // pixel color of the current LED
    always_comb
    begin
        idx       = 8'(cnt_reg);
        mirror    = 8'(LED_COUNT - 1) - desc_reg.param;
        ring_dist = (idx >= desc_reg.param) ? idx - desc_reg.param
                                            : idx + 8'(LED_COUNT) - desc_reg.param;
        px_r   = 8'd0;
        px_g   = 8'd0;
        px_b   = 8'd0;
        case (desc_reg.kind)
            KIND_SWEEP:
            begin
                if (idx == desc_reg.param || idx == mirror)
                begin
                    px_g = GREEN_G;
                    px_b = GREEN_B;
                end
                else if (idx < desc_reg.param || idx > mirror)
                    px_b = BLUE_B;
            end
            KIND_BLINK:
            begin
                if (idx[0] ^ desc_reg.param[0])
                begin
                    px_g = GREEN_G;
                    px_b = GREEN_B;
                end
                else
                    px_b = BLUE_B;
            end
            KIND_GREEN:
            begin
                px_g = GREEN_G;
                px_b = GREEN_B;
            end
            KIND_RED:
            begin
                px_r = desc_reg.param;
            end
            KIND_SCROLL:
            begin
                if (ring_dist < 8'(SCROLL_LIT))
                begin
                    px_r = SCROLL_LEVEL;
                    px_g = SCROLL_LEVEL;
                end
            end
            default:
            begin
                px_r = 8'd0;
            end
        endcase
    end

    // frame walk control
    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = load ? busy_reg : out_valid_reg;
        if (q_pop)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (emit && cnt_last)
            busy_next = 1'b0;
        else if (emit)
            cnt_next = cnt_reg + LED_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // frame descriptor and output register
    always_ff @(posedge clk)
    begin
        if (q_pop)
            desc_reg <= q_pop_data;
        if (emit)
        begin
            led_index_reg <= 4'(cnt_reg);
            red_reg       <= px_r;
            green_reg     <= px_g;
            blue_reg      <= px_b;
            last_reg      <= cnt_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign led_index = led_index_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign last      = last_reg;

endmodule

FILE: rtl/led_ring_effect_sequencer.sv
// LED ring effect sequencer
// Input channel (in_valid/in_ready) carries ticks, mode requests and mic
// samples; op selects which. Only ticks that change the picture produce
// output: one frame of LED_COUNT transfers (12 by default), LED 0 first,
// with last set on the final LED.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) set the tick
// periods of sweeps, blink, scroll and fades; write them while idle.
// Throughput: one input transfer per cycle while the frame queue has room;
// the renderer sends one LED per cycle while out_ready is high, with no gap
// between queued frames, and ticks are held back once the queue is full.
// A frame passes the queue entry, the renderer's descriptor register and
// the output register before its first LED appears.
// A two-entry frame queue sits between the decoder and the renderer; when
// out_ready is low the output register holds, the renderer stops, the
// queue fills and in_ready drops.
// Reset clears the mode to idle, all timers and the queue, and restores
// the default periods (3, 10, 12, 1 ticks); no frame is shown at reset.
module led_ring_effect_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [3:0] mode_req,
    input  logic       mic_muted,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] led_index,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic       last
);
    import lres_pkg::*;

    frame_desc_t push_data;
    frame_desc_t pop_data;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;

    // item decode and mode sequencing
    lres_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .mode_req    (mode_req),
        .mic_muted   (mic_muted),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (push_data)
    );

    // frame queue
    lres_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // frame renderer
    lres_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop_data (pop_data),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .led_index  (led_index),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .last       (last)
    );

endmodule

FILE: rtl/lres_checker.sv
module lres_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] led_index,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic       last
);
    import lres_pkg::*;

    // nothing is offered while in reset
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid during reset");

    // a stalled LED holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(led_index) && $stable(red) &&
                                    $stable(green) && $stable(blue) && $stable(last))
        else $error("stalled output changed");

    // last marks the final LED of the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> led_index == 4'(LED_COUNT - 1))
        else $error("last on wrong LED");

    // within a frame the LEDs follow each other without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=>
            out_valid && led_index == $past(led_index) + 4'd1)
        else $error("frame LED sequence broken");

endmodule

bind led_ring_effect_sequencer lres_checker u_lres_checker (.*);

FILE: test/led_ring_effect_sequencer_tb.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lres_pkg::*;

    // codes the block has to ignore
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [3:0] REQ_UNKNOWN = 4'd15;

    localparam int QUIET_LIMIT = 3000;
    localparam int ERR_PRINT   = 30;
    localparam int PHASES      = 5;

    // one expected LED transfer
    typedef struct {
        logic [3:0] idx;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       lst;
    } led_px_t;

    // one row of the opening sequence; typed rows carry a hand-written LED count and LED 0
    typedef struct packed {
        logic [1:0] opc;
        logic [3:0] req;
        logic       mic;
        logic [7:0] reps;
        logic       typed;
        logic [4:0] leds;
        logic [7:0] r0;
        logic [7:0] g0;
        logic [7:0] b0;
    } plan_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] op = OP_TICK;
    logic [3:0] mode_req = MODE_IDLE;
    logic       mic_muted = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = CFG_SWEEP;
    logic [7:0] cfg_data = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [3:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;

    led_ring_effect_sequencer dut (.*);

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ring predictor state
    logic [7:0] sweep_per = 8'd3;
    logic [7:0] blink_per = 8'd10;
    logic [7:0] scroll_per = 8'd12;
    logic [7:0] fade_per = 8'd1;
    logic [3:0] shown_mode = MODE_IDLE;
    logic [3:0] wanted_mode = MODE_IDLE;
    int         frame_no = 0;
    int         tick_cnt = 0;
    logic       blink_ph = 1'b0;
    int         scroll_at = 0;
    logic       running = 1'b0;
    logic       last_mic = 1'b0;
    logic [7:0] pix_r [LED_COUNT];
    logic [7:0] pix_g [LED_COUNT];
    logic [7:0] pix_b [LED_COUNT];

    led_px_t led_due_q [$];

    int errors = 0;
    int in_xfers = 0;
    int led_xfers = 0;
    int frames_seen = 0;
    int burst_left = 0;
    int quiet_cyc = 0;
    logic [7:0] rx_cyc = 8'd0;

    // opening sequence, run with sweep and fade periods of one tick
    plan_row_t opening_plan [24] = '{
        '{OP_TICK,   MODE_IDLE,   1'b0, 8'd1, 1'b1, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_UNUSED, REQ_UNKNOWN, 1'b1, 8'd1, 1'b1, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_MODE,   REQ_UNKNOWN, 1'b0, 8'd1, 1'b1, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_TICK,   MODE_IDLE,   1'b0, 8'd1, 1'b1, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_MIC,    MODE_IDLE,   1'b0, 8'd1, 1'b1, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_MODE,   MODE_START,  1'b0, 8'd1, 1'b1, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_TICK,   MODE_IDLE,   1'b0, 8'd1, 1'b1, 5'd12, 8'h00, GREEN_G, GREEN_B},
        '{OP_MIC,    MODE_IDLE,   1'b1, 8'd1, 1'b1, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_MODE,   MODE_SPEAK,  1'b0, 8'd1, 1'b1, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_TICK,   MODE_IDLE,   1'b0, 8'd5, 1'b0, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_TICK,   MODE_IDLE,   1'b0, 8'd1, 1'b1, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_TICK,   MODE_IDLE,   1'b0, 8'd1, 1'b1, 5'd12, 8'h00, GREEN_G, GREEN_B},
        '{OP_TICK,   MODE_IDLE,   1'b0, 8'd1, 1'b1, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_MODE,   MODE_THINK,  1'b0, 8'd1, 1'b1, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_TICK,   MODE_IDLE,   1'b0, 8'd1, 1'b1, 5'd12, 8'h00, 8'h00,   BLUE_B},
        '{OP_TICK,   MODE_IDLE,   1'b0, 8'd6, 1'b0, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_TICK,   MODE_IDLE,   1'b0, 8'd1, 1'b1, 5'd12, 8'h00, 8'h00,   BLUE_B},
        '{OP_MODE,   MODE_BTDISC, 1'b0, 8'd1, 1'b1, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_TICK,   MODE_IDLE,   1'b0, 8'd1, 1'b1, 5'd12, SCROLL_LEVEL, SCROLL_LEVEL, 8'h00},
        '{OP_MIC,    MODE_IDLE,   1'b1, 8'd1, 1'b1, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_MIC,    MODE_IDLE,   1'b0, 8'd1, 1'b1, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_TICK,   MODE_IDLE,   1'b0, 8'd1, 1'b1, 5'd12, UNMUTE_RED, 8'h00, 8'h00},
        '{OP_TICK,   MODE_IDLE,   1'b0, 8'd1, 1'b0, 5'd0,  8'h00, 8'h00,   8'h00},
        '{OP_MODE,   MODE_IDLE,   1'b0, 8'd1, 1'b1, 5'd0,  8'h00, 8'h00,   8'h00}
    };

    // picture drawing
    function automatic void paint_all(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
        for (int i = 0; i < LED_COUNT; i++)
        begin
            pix_r[i] = r;
            pix_g[i] = g;
            pix_b[i] = b;
        end
    endfunction

    function automatic void paint_sweep(input int m);
        paint_all(8'h00, 8'h00, 8'h00);
        if (m >= 0)
        begin
            for (int i = 0; i < LED_COUNT; i++)
            begin
                if (i == m || i == LED_COUNT - 1 - m)
                begin
                    pix_g[i] = GREEN_G;
                    pix_b[i] = GREEN_B;
                end
                else if (i < m || i > LED_COUNT - 1 - m)
                    pix_b[i] = BLUE_B;
            end
        end
    endfunction

    function automatic void paint_blink(input logic ph);
        for (int i = 0; i < LED_COUNT; i++)
        begin
            pix_r[i] = 8'h00;
            pix_g[i] = ((i[0] ^ ph) != 1'b0) ? GREEN_G : 8'h00;
            pix_b[i] = ((i[0] ^ ph) != 1'b0) ? GREEN_B : BLUE_B;
        end
    endfunction

    function automatic void paint_scroll(input int s);
        int at;
        paint_all(8'h00, 8'h00, 8'h00);
        for (int j = 0; j < SCROLL_LIT; j++)
        begin
            at = (s + j) % LED_COUNT;
            pix_r[at] = SCROLL_LEVEL;
            pix_g[at] = SCROLL_LEVEL;
        end
    endfunction

    // tick divider; a zero period behaves as one tick
    function automatic logic period_elapsed(input logic [7:0] per);
        int span;
        span = (per == 8'd0) ? 1 : int'(per);
        if (tick_cnt + 1 >= span)
        begin
            tick_cnt = 0;
            return 1'b1;
        end
        tick_cnt++;
        return 1'b0;
    endfunction

    // switch to a new mode and draw its first picture
    function automatic logic enter_mode(input logic [3:0] m);
        shown_mode = m;
        frame_no = 0;
        tick_cnt = 0;
        blink_ph = 1'b0;
        scroll_at = 0;
        running = 1'b0;
        case (m)
            MODE_IDLE:
            begin
                paint_all(8'h00, 8'h00, 8'h00);
                return 1'b1;
            end
            MODE_START:
            begin
                running = 1'b1;
                paint_sweep(0);
                return 1'b1;
            end
            MODE_END:
            begin
                running = 1'b1;
                frame_no = 1;
                paint_sweep(HALF_RING - 1);
                return 1'b1;
            end
            MODE_THINK:
            begin
                paint_blink(1'b0);
                return 1'b1;
            end
            MODE_SPEAK:
            begin
                running = 1'b1;
                paint_all(8'h00, GREEN_G, GREEN_B);
                return 1'b1;
            end
            MODE_MUTE:
            begin
                running = 1'b1;
                paint_all(8'h00, 8'h00, 8'h00);
                return 1'b1;
            end
            MODE_UNMUTE:
            begin
                running = 1'b1;
                paint_all(UNMUTE_RED, 8'h00, 8'h00);
                return 1'b1;
            end
            MODE_BTDISC:
            begin
                paint_scroll(0);
                scroll_at = 1 % LED_COUNT;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // closing sweep from the middle outward, then a black frame
    function automatic logic sweep_down_step();
        if (!period_elapsed(sweep_per))
            return 1'b0;
        frame_no++;
        paint_sweep(HALF_RING - frame_no);
        if (frame_no >= HALF_RING + 1)
            running = 1'b0;
        return 1'b1;
    endfunction

    // one tick of the mode on show
    function automatic logic advance_anim();
        case (shown_mode)
            MODE_START:
            begin
                if (!running)
                    return 1'b0;
                if (!period_elapsed(sweep_per))
                    return 1'b0;
                frame_no++;
                if (frame_no >= HALF_RING)
                begin
                    running = 1'b0;
                    return 1'b0;
                end
                paint_sweep(frame_no);
                return 1'b1;
            end
            MODE_END:
            begin
                if (!running)
                    return 1'b0;
                return sweep_down_step();
            end
            MODE_SPEAK:
            begin
                if (!running)
                    return 1'b0;
                if (frame_no == 0)
                begin
                    if (wanted_mode == MODE_SPEAK)
                        return 1'b0;
                    frame_no = 1;
                    tick_cnt = 0;
                    paint_sweep(HALF_RING - 1);
                    return 1'b1;
                end
                return sweep_down_step();
            end
            MODE_THINK:
            begin
                if (!period_elapsed(blink_per))
                    return 1'b0;
                blink_ph = ~blink_ph;
                paint_blink(blink_ph);
                return 1'b1;
            end
            MODE_MUTE:
            begin
                if (!running)
                    return 1'b0;
                if (!period_elapsed(fade_per))
                    return 1'b0;
                frame_no++;
                if (frame_no >= MUTE_FRAMES)
                begin
                    running = 1'b0;
                    return 1'b0;
                end
                paint_all(8'(2 * frame_no), 8'h00, 8'h00);
                return 1'b1;
            end
            MODE_UNMUTE:
            begin
                if (!running)
                    return 1'b0;
                if (!period_elapsed(fade_per))
                    return 1'b0;
                frame_no++;
                if (frame_no >= UNMUTE_FRAMES)
                begin
                    running = 1'b0;
                    return 1'b0;
                end
                paint_all(8'(int'(UNMUTE_RED) - 2 * frame_no), 8'h00, 8'h00);
                return 1'b1;
            end
            MODE_BTDISC:
            begin
                if (!period_elapsed(scroll_per))
                    return 1'b0;
                paint_scroll(scroll_at);
                scroll_at = (scroll_at + 1) % LED_COUNT;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // apply one accepted input; queues the LEDs of any frame it causes
    function automatic int animate_item(input logic [1:0] opc, input logic [3:0] req,
                                        input logic mic);
        logic    shown;
        led_px_t px;
        if (opc == OP_MODE)
        begin
            if (req <= MODE_BTDISC)
                wanted_mode = req;
            return 0;
        end
        if (opc == OP_MIC)
        begin
            if (mic == last_mic)
                return 0;
            if (mic)
            begin
                // mute is dropped while a listening or speaking mode is wanted
                if (wanted_mode >= MODE_START && wanted_mode <= MODE_SPEAK)
                    return 0;
                wanted_mode = MODE_MUTE;
            end
            else
                wanted_mode = MODE_UNMUTE;
            last_mic = mic;
            return 0;
        end
        if (opc != OP_TICK)
            return 0;
        if (!running && wanted_mode != shown_mode)
            shown = enter_mode(wanted_mode);
        else
            shown = advance_anim();
        if (!shown)
            return 0;
        for (int i = 0; i < LED_COUNT; i++)
        begin
            px.idx = 4'(i);
            px.r = pix_r[i];
            px.g = pix_g[i];
            px.b = pix_b[i];
            px.lst = (i == LED_COUNT - 1);
            led_due_q.push_back(px);
        end
        return LED_COUNT;
    endfunction

    // input transfer, with bursts and gaps on the sending side
    task automatic send_item(input logic [1:0] opc, input logic [3:0] req, input logic mic,
                             output int n_leds);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        op <= opc;
        mode_req <= req;
        mic_muted <= mic;
        do
            @(posedge clk);
        while (!in_ready);
        n_leds = animate_item(opc, req, mic);
        in_xfers++;
    endtask

    // hold the input side until every queued LED has come out
    task automatic drain_frames();
        in_valid <= 1'b0;
        burst_left = 0;
        while (led_due_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        case (idx)
            CFG_SWEEP:  sweep_per = v;
            CFG_BLINK:  blink_per = v;
            CFG_SCROLL: scroll_per = v;
            CFG_FADE:   fade_per = v;
            default: ;
        endcase
    endtask

    task automatic write_periods(input logic [7:0] s, input logic [7:0] b,
                                 input logic [7:0] sc, input logic [7:0] f);
        write_reg(CFG_SWEEP, s);
        write_reg(CFG_BLINK, b);
        write_reg(CFG_SCROLL, sc);
        write_reg(CFG_FADE, f);
        cfg_wr_en <= 1'b0;
    endtask

    // receiver: free-running, then a regular stall, then random stalls
    always @(posedge clk)
    begin
        rx_cyc <= rx_cyc + 8'd1;
        if (rx_cyc[7:6] == 2'b00)
            out_ready <= 1'b1;
        else if (rx_cyc[7:6] == 2'b01)
            out_ready <= (rx_cyc[1:0] != 2'b11);
        else
            out_ready <= ($urandom_range(0, 99) < 60);
    end

    // LED transfer checker
    always @(posedge clk)
    begin
        led_px_t want;
        if (rst_n && out_valid && out_ready)
        begin
            led_xfers++;
            if (last)
                frames_seen++;
            if (led_due_q.size() == 0)
            begin
                errors++;
                if (errors <= ERR_PRINT)
                    $display("%0t: unexpected LED transfer idx %0d rgb %h %h %h last %b",
                             $time, led_index, red, green, blue, last);
            end
            else
            begin
                want = led_due_q.pop_front();
                if (led_index !== want.idx || red !== want.r || green !== want.g ||
                    blue !== want.b || last !== want.lst)
                begin
                    errors++;
                    if (errors <= ERR_PRINT)
                        $display("%0t: LED mismatch expected idx %0d rgb %h %h %h last %b, got idx %0d rgb %h %h %h last %b",
                                 $time, want.idx, want.r, want.g, want.b, want.lst,
                                 led_index, red, green, blue, last);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cyc <= 0;
        else
        begin
            quiet_cyc <= quiet_cyc + 1;
            if (quiet_cyc >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d LEDs still due",
                         $time, quiet_cyc, led_due_q.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        plan_row_t row;
        int        n;
        int        budget;
        int        run;
        int        pick;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening sequence with fast sweeps and fades
        write_periods(8'd1, 8'd10, 8'd12, 8'd1);
        foreach (opening_plan[k])
        begin
            row = opening_plan[k];
            for (int j = 0; j < row.reps; j++)
                send_item(row.opc, row.req, row.mic, n);
            if (row.typed && (n != row.leds ||
                (n != 0 && (pix_r[0] != row.r0 || pix_g[0] != row.g0 ||
                            pix_b[0] != row.b0))))
            begin
                errors++;
                $display("%0t: row %0d expected %0d LEDs, LED 0 rgb %h %h %h, predicted %0d, rgb %h %h %h",
                         $time, k, row.leds, row.r0, row.g0, row.b0,
                         n, pix_r[0], pix_g[0], pix_b[0]);
            end
        end

        // random phases, each at its own set of periods
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_frames();
            case (ph)
                0: write_periods(8'd1, 8'd1, 8'd1, 8'd1);
                1: write_periods(8'd0, 8'd0, 8'd0, 8'd0);
                2: write_periods(8'd255, 8'd255, 8'd255, 8'd255);
                3: write_periods(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                                 8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)));
                default: write_periods(8'($urandom_range(1, 6)), 8'($urandom_range(1, 12)),
                                       8'($urandom_range(1, 12)), 8'($urandom_range(1, 3)));
            endcase
            budget = 22;
            while (budget > 0)
            begin
                // lead item: mostly a valid mode request, some mic samples and noise
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    send_item(OP_MODE, 4'($urandom_range(MODE_IDLE, MODE_BTDISC)),
                              1'($urandom_range(0, 1)), n);
                else if (pick < 17)
                    send_item(OP_MIC, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), n);
                else if (pick < 19)
                    send_item(OP_UNUSED, 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), n);
                else
                    send_item(OP_MODE, 4'($urandom_range(MODE_BTDISC + 1, REQ_UNKNOWN)),
                              1'($urandom_range(0, 1)), n);
                // run of ticks, now and then a mic sample in between
                run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 36);
                for (int t = 0; t < run && budget > 0; t++)
                begin
                    if ($urandom_range(0, 24) == 0)
                        send_item(OP_MIC, 4'($urandom_range(0, 15)),
                                  1'($urandom_range(0, 1)), n);
                    send_item(OP_TICK, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), n);
                    budget--;
                end
            end
        end

        drain_frames();
        repeat (8) @(posedge clk);

        $display("run covered %0d input transfers and %0d LED transfers in %0d frames",
                 in_xfers, led_xfers, frames_seen);
        $display("opening sequence plus %0d random phases, periods from 0 up to 255 ticks",
                 PHASES);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/lres_pkg.sv
rtl/lres_front.sv
rtl/lres_queue.sv
rtl/lres_back.sv
rtl/led_ring_effect_sequencer.sv
rtl/lres_checker.sv
test/led_ring_effect_sequencer_tb.sv
